// File: sv/u2u8_pkg.sv
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies; used by every module of the block
package u2u8_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_LIMIT      = 1'd1;

    localparam logic [2:0] STAT_RUNNING  = 3'd0;
    localparam logic [2:0] STAT_ZERO_END = 3'd1;
    localparam logic [2:0] STAT_NO_ROOM  = 3'd2;
    localparam logic [2:0] STAT_LIMIT    = 3'd3;
    localparam logic [2:0] STAT_IGNORED  = 3'd4;

    localparam logic [15:0] SURR_LO    = 16'hD800;
    localparam logic [15:0] SURR_HI    = 16'hDFFF;
    localparam logic [15:0] ONE_MAX    = 16'h007F;
    localparam logic [15:0] TWO_MAX    = 16'h07FF;
    localparam logic [7:0]  LEAD2      = 8'hC0;
    localparam logic [7:0]  LEAD3      = 8'hE0;
    localparam logic [7:0]  CONT       = 8'h80;
    localparam logic [7:0]  SURR_BYTE  = 8'h40;

    // one classified unit waiting for the byte serializer
    typedef struct packed {
        logic [2:0][7:0]        bytes;   // bytes[0] goes out first
        logic [1:0]             nbytes;  // zero: one beat without a byte
        logic [2:0]             status;
        logic [COUNT_WIDTH-1:0] base;    // written count before this item
    } job_t;

endpackage

// File: sv/utf16_to_utf8_encoder.sv
// utf-16 code unit to utf-8 byte encoder, one beat per output byte, or a lone empty beat
// path: a taken unit is written into a queue slot, then loaded into the serializer job
// register, which raises m_tvalid; throughput: one unit per cycle in while the 4-job queue
// has room, 1 to 3 beats out per unit (one per cycle while m_tready is high, no gap between
// queued jobs), so sustained rate is set by the byte-wide result channel; reset: aresetn
// synchronous active low, clears config, string state, queue
module utf16_to_utf8_encoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [15:0]                         cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,   // code_unit
    input  logic                                s_tuser,   // first_of_string
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [31:0]                         m_tdata,   // out_byte, status, bytes_written
    output logic                                m_tuser,   // byte_present
    output logic                                m_tlast    // last_of_run
);

    u2u8_pkg::job_t push_job, head_job;
    logic           push, full, pop, avail;

    u2u8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_code   (s_tdata),
        .in_first  (s_tuser),
        .q_full    (full),
        .q_push    (push),
        .q_job     (push_job)
    );

    u2u8_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_job  (push_job),
        .full      (full),
        .pop       (pop),
        .avail     (avail),
        .head_job  (head_job)
    );

    u2u8_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_avail   (avail),
        .q_head    (head_job),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: sv/u2u8_front.sv
// front end: config registers, string state and classification of each code unit
// depends on u2u8_pkg
module u2u8_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [u2u8_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [15:0]                         cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [15:0]                         in_code,
    input  logic                                in_first,
    input  logic                                q_full,
    output logic                                q_push,
    output u2u8_pkg::job_t                      q_job
);

    logic [15:0]                        cap_reg;
    logic [15:0]                        limit_reg;
    logic [u2u8_pkg::COUNT_WIDTH-1:0]   room_reg, room_next;
    logic [u2u8_pkg::COUNT_WIDTH-1:0]   units_reg, units_next;
    logic [u2u8_pkg::COUNT_WIDTH-1:0]   written_reg, written_next;
    logic                               fin_reg, fin_next;

    logic [u2u8_pkg::COUNT_WIDTH-1:0]   room_eff, units_eff, written_eff, units_inc, cap_sat;
    logic                               fin_eff;
    logic                               is_surr, is_one, is_two;
    logic [1:0]                         n;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= '0;
            limit_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                u2u8_pkg::REG_OUTPUT_CAPACITY: cap_reg   <= cfg_wdata;
                u2u8_pkg::REG_UNIT_LIMIT:      limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (32'(cap_reg) > 32'(u2u8_pkg::CNT_MAX))
            cap_sat = u2u8_pkg::CNT_MAX;
        else
            cap_sat = u2u8_pkg::COUNT_WIDTH'(cap_reg);

        room_eff    = in_first ? cap_sat : room_reg;
        units_eff   = in_first ? '0 : units_reg;
        written_eff = in_first ? '0 : written_reg;
        fin_eff     = in_first ? 1'b0 : fin_reg;

        units_inc = (units_eff == u2u8_pkg::CNT_MAX) ? units_eff : units_eff + 1'b1;

        is_surr = (in_code >= u2u8_pkg::SURR_LO) && (in_code <= u2u8_pkg::SURR_HI);
        is_one  = in_code <= u2u8_pkg::ONE_MAX;
        is_two  = in_code <= u2u8_pkg::TWO_MAX;

        q_job.bytes  = '0;
        q_job.nbytes = 2'd0;
        q_job.status = u2u8_pkg::STAT_RUNNING;
        q_job.base   = written_eff;
        n            = 2'd0;

        room_next    = room_eff;
        units_next   = units_eff;
        written_next = written_eff;
        fin_next     = fin_eff;

        if (fin_eff) begin
            q_job.status = u2u8_pkg::STAT_IGNORED;
        end else if (room_eff == '0) begin
            q_job.status = u2u8_pkg::STAT_NO_ROOM;
            fin_next     = 1'b1;
        end else begin
            units_next = units_inc;
            if (is_surr) begin
                n = 2'd1;
                q_job.bytes[0] = u2u8_pkg::SURR_BYTE;
            end else if (is_one) begin
                n = 2'd1;
                q_job.bytes[0] = in_code[7:0];
            end else if (is_two) begin
                if (room_eff >= u2u8_pkg::COUNT_WIDTH'(2)) begin
                    n = 2'd2;
                    q_job.bytes[0] = u2u8_pkg::LEAD2 | {3'b000, in_code[10:6]};
                    q_job.bytes[1] = u2u8_pkg::CONT | {2'b00, in_code[5:0]};
                end
            end else begin
                if (room_eff >= u2u8_pkg::COUNT_WIDTH'(3)) begin
                    n = 2'd3;
                    q_job.bytes[0] = u2u8_pkg::LEAD3 | {4'b0000, in_code[15:12]};
                    q_job.bytes[1] = u2u8_pkg::CONT | {2'b00, in_code[11:6]};
                    q_job.bytes[2] = u2u8_pkg::CONT | {2'b00, in_code[5:0]};
                end
            end

            if (n == 2'd0) begin
                // multi-byte form does not fit in the room left
                q_job.status = u2u8_pkg::STAT_NO_ROOM;
                fin_next     = 1'b1;
            end else begin
                q_job.nbytes = n;
                room_next    = room_eff - u2u8_pkg::COUNT_WIDTH'(n);
                written_next = written_eff + u2u8_pkg::COUNT_WIDTH'(n);
                if (in_code == 16'd0)
                    q_job.status = u2u8_pkg::STAT_ZERO_END;
                else if (limit_reg != 16'd0 && 32'(units_inc) >= 32'(limit_reg))
                    q_job.status = u2u8_pkg::STAT_LIMIT;
                else if (room_next == '0)
                    q_job.status = u2u8_pkg::STAT_NO_ROOM;
                if (q_job.status != u2u8_pkg::STAT_RUNNING)
                    fin_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            room_reg    <= '0;
            units_reg   <= '0;
            written_reg <= '0;
            fin_reg     <= 1'b0;
        end else if (q_push) begin
            room_reg    <= room_next;
            units_reg   <= units_next;
            written_reg <= written_next;
            fin_reg     <= fin_next;
        end
    end

endmodule

// File: sv/u2u8_queue.sv
// short job queue between the classifier and the byte serializer
// depends on u2u8_pkg
module u2u8_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  u2u8_pkg::job_t  push_job,
    output logic            full,
    input  logic            pop,
    output logic            avail,
    output u2u8_pkg::job_t  head_job
);

    u2u8_pkg::job_t                 slot_reg [u2u8_pkg::QUEUE_DEPTH];
    logic [u2u8_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [u2u8_pkg::QPTR_W:0]      cnt_reg;

    assign full     = cnt_reg == (u2u8_pkg::QPTR_W+1)'(u2u8_pkg::QUEUE_DEPTH);
    assign avail    = cnt_reg != '0;
    assign head_job = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push)
            slot_reg[wptr_reg] <= push_job;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: sv/u2u8_back.sv
// back end: one result beat per job byte, or one empty beat if none
// depends on u2u8_pkg
module u2u8_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_avail,
    input  u2u8_pkg::job_t              q_head,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,
    output logic                        m_tuser,
    output logic                        m_tlast
);

    u2u8_pkg::job_t                     job_reg;
    logic                               busy_reg;
    logic [1:0]                         k_reg;
    logic                               present, last, beat;
    logic [7:0]                         byte_out;
    logic [u2u8_pkg::COUNT_WIDTH-1:0]   written;

    always_comb begin
        present  = job_reg.nbytes != 2'd0;
        last     = !present || (k_reg == job_reg.nbytes - 2'd1);
        byte_out = present ? job_reg.bytes[k_reg] : 8'd0;
        written  = present ? job_reg.base + u2u8_pkg::COUNT_WIDTH'(k_reg) + 1'b1
                           : job_reg.base;
        beat     = busy_reg && m_tready;
        q_pop    = q_avail && (!busy_reg || (beat && last));
    end

    assign m_tvalid = busy_reg;
    assign m_tuser  = present;
    assign m_tlast  = last;
    assign m_tdata  = {5'd0, 16'(written), job_reg.status, byte_out};

    always_ff @(posedge aclk) begin
        if (q_pop)
            job_reg <= q_head;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            k_reg    <= 2'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            k_reg    <= 2'd0;
        end else if (beat) begin
            if (last)
                busy_reg <= 1'b0;
            else
                k_reg <= k_reg + 2'd1;
        end
    end

endmodule

// File: sv/u2u8_checker.sv
// port-level checks for the encoder, attached by bind
// depends on u2u8_pkg and utf16_to_utf8_encoder
module u2u8_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast
);

    // a stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a beat without a byte is the only beat of its item and carries a zero byte
    a_nobyte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
        else $error("beat without byte is not a lone zero beat");

    // ignored items never carry a byte
    a_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[10:8] == u2u8_pkg::STAT_IGNORED) |-> !m_tuser)
        else $error("ignored item produced a byte");

    // status stays within its defined codes
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[10:8] <= u2u8_pkg::STAT_IGNORED)
        else $error("undefined status code");

    // nothing is offered right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
